// ===== design/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within a frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [1:0] ST_HUM_CRC  = 2'd2;

    // Scale factors of the conversion, denominator 65535 in both
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // One decoded frame, handed from front to back
    typedef struct packed {
        logic [15:0] temp_code;
        logic [15:0] hum_raw;
        logic [1:0]  status;
    } job_t;

    // Not-empty and full flags of the job queue; not_empty goes to the back part, full to the input ready
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_flags_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== design/humidity_sensor_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_top
// Six-byte measurement frame decoder with CRC-8 checks and unit scaling.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input stalls only while the two-entry
//   job queue is full.
// Path: after the sixth byte of a frame is accepted, its job passes through the
//   queue, the multiply stage and the divide-and-offset stage to the output register.
// Reset: asynchronous, active low; byte position 0, CRC 0xFF, queue empty.
module humidity_sensor_frame_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [14:0] temperature_centi, [28:15] humidity_centi,
                                   // [30:29] status, [31] zero
);
    import hsfd_pkg::*;

    logic         accept;
    logic         push;
    job_t         push_job;
    logic         pop;
    job_t         pop_job;
    queue_flags_t flags;
    logic [14:0]  temperature_centi;
    logic [13:0]  humidity_centi;
    logic [1:0]   status;

    assign s_tready = !flags.full;
    assign accept   = s_tvalid && s_tready;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .push_job    (push_job)
    );

    hsfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .flags    (flags)
    );

    hsfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .flags             (flags),
        .pop_job           (pop_job),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status)
    );

    assign m_tdata = {1'b0, status, humidity_centi, temperature_centi};

endmodule

// ===== design/hsfd_front.sv =====
// ----------------------------------------------------------------------------
// hsfd_front
// Tracks the byte position, runs the CRC checks and pushes one job per frame.
// ----------------------------------------------------------------------------
module hsfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               push,
    output hsfd_pkg::job_t     push_job
);
    import hsfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  hum_msb_reg, hum_msb_next;
    logic [7:0]  hum_lsb_reg, hum_lsb_next;
    logic        temp_bad_reg, temp_bad_next;
    logic [2:0]  pos;
    logic        last_byte;

    // Resync on frame_start or an unreachable position
    assign pos = (frame_start || pos_reg > POS_H_CRC) ? POS_T_MSB : pos_reg;
    assign last_byte = (pos == POS_H_CRC);

    always_comb
    begin
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_msb_next   = hum_msb_reg;
        temp_bad_next  = temp_bad_reg;
        unique case (pos)
            POS_T_MSB:
            begin
                crc_next       = crc8_byte(CRC_INIT, rx_byte);
                temp_word_next = {rx_byte, 8'h00};
                temp_bad_next  = 1'b0;
            end
            POS_T_LSB:
            begin
                crc_next       = crc8_byte(crc_reg, rx_byte);
                temp_word_next = {temp_word_reg[15:8], rx_byte};
            end
            POS_T_CRC:
            begin
                temp_bad_next = (crc_reg != rx_byte);
                crc_next      = CRC_INIT;
            end
            POS_H_MSB:
            begin
                crc_next     = crc8_byte(CRC_INIT, rx_byte);
                hum_msb_next = rx_byte;
            end
            POS_H_LSB:
            begin
                crc_next = crc8_byte(crc_reg, rx_byte);
            end
            default:
            begin
                crc_next = CRC_INIT;
            end
        endcase
        pos_next = last_byte ? POS_T_MSB : pos + 3'd1;
    end

    // Humidity LSB is kept in its own register, hum_lsb_reg
    assign hum_lsb_next = (pos == POS_H_LSB) ? rx_byte : hum_lsb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= '0;
            hum_msb_reg   <= '0;
            hum_lsb_reg   <= '0;
            temp_bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_msb_reg   <= hum_msb_next;
            hum_lsb_reg   <= hum_lsb_next;
            temp_bad_reg  <= temp_bad_next;
        end
    end

    assign push               = accept && last_byte;
    assign push_job.temp_code = temp_word_reg;
    assign push_job.hum_raw   = {hum_msb_reg, hum_lsb_reg};
    assign push_job.status    = temp_bad_reg ? ST_TEMP_CRC :
                                (crc_reg != rx_byte) ? ST_HUM_CRC : ST_OK;

endmodule

// ===== design/hsfd_queue.sv =====
// ----------------------------------------------------------------------------
// hsfd_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module hsfd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hsfd_pkg::job_t         push_job,
    input  logic                   pop,
    output hsfd_pkg::job_t         pop_job,
    output hsfd_pkg::queue_flags_t flags
);
    import hsfd_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign pop_job         = mem[rd_ptr_reg];
    assign flags.not_empty = (count_reg != 2'd0);
    assign flags.full      = (count_reg == 2'd2);

endmodule

// ===== design/hsfd_back.sv =====
// ----------------------------------------------------------------------------
// hsfd_back
// Scales raw words to centi-units: constant multiply, then divide by 65535; temperature also loses its offset.
// ----------------------------------------------------------------------------
module hsfd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hsfd_pkg::queue_flags_t flags,
    input  hsfd_pkg::job_t         pop_job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [14:0]            temperature_centi,
    output logic [13:0]            humidity_centi,
    output logic [1:0]             status
);
    import hsfd_pkg::*;

    logic        advance;
    logic        s1_valid_reg;
    logic [30:0] temp_prod_reg;
    logic [29:0] hum_prod_reg;
    logic [1:0]  s1_status_reg;
    logic        out_valid_reg;
    logic [14:0] temp_out_reg;
    logic [13:0] hum_out_reg;
    logic [1:0]  status_out_reg;

    logic [14:0] temp_q0;
    logic [16:0] temp_rem;
    logic [14:0] temp_q;
    logic [15:0] temp_signed;
    logic [13:0] hum_q0;
    logic [16:0] hum_rem;
    logic [13:0] hum_q;

    // Whole pipeline moves when the output register is free or being taken
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && flags.not_empty;

    // x = q0*65536 + lo = q0*65535 + (q0 + lo); remainder stays below 2*65535
    assign temp_q0     = temp_prod_reg[30:16];
    assign temp_rem    = {2'b00, temp_q0} + {1'b0, temp_prod_reg[15:0]};
    assign temp_q      = temp_q0 + {14'd0, (temp_rem >= FULL_SCALE)};
    assign temp_signed = {1'b0, temp_q} - TEMP_OFFSET;

    assign hum_q0  = hum_prod_reg[29:16];
    assign hum_rem = {3'b000, hum_q0} + {1'b0, hum_prod_reg[15:0]};
    assign hum_q   = hum_q0 + {13'd0, (hum_rem >= FULL_SCALE)};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            temp_prod_reg <= 31'(pop_job.temp_code) * 31'(TEMP_SCALE);
            hum_prod_reg  <= 30'(pop_job.hum_raw) * 30'(HUM_SCALE);
            s1_status_reg <= pop_job.status;
        end
        if (advance && s1_valid_reg)
        begin
            status_out_reg <= s1_status_reg;
            // Drop both values on a CRC failure
            if (s1_status_reg == ST_OK)
            begin
                temp_out_reg <= temp_signed[14:0];
                hum_out_reg  <= hum_q;
            end
            else
            begin
                temp_out_reg <= '0;
                hum_out_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_out_reg;
    assign humidity_centi    = hum_out_reg;
    assign status            = status_out_reg;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the measurement frame decoder. Byte items go in on the
// slave side with random gaps; decoded readings come out on the master side
// with random stalls. A local tracker of the frame position, CRC and raw
// words predicts each reading, and every accepted reading is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    import hsfd_pkg::*;

    localparam int LIMIT_TIME = 3_000_000;

    typedef struct packed {
        logic [14:0] temp;
        logic [13:0] hum;
        logic [1:0]  status;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [14:0] temperature, [28:15] humidity,
                                    // [30:29] status, [31] zero

    // Tracker of the frame being received
    logic [2:0]  frame_pos = POS_T_MSB;
    logic [7:0]  crc_acc = CRC_INIT;
    logic [15:0] temp_word = 16'h0000;
    logic [15:0] hum_word = 16'h0000;
    logic        temp_bad = 1'b0;

    reading_t    expected_readings[$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_req = 0;

    int bytes_sent = 0;
    int readings_checked = 0;
    int crc_fail_seen = 0;
    int resyncs = 0;
    int mismatch_count = 0;
    int error_count = 0;

    humidity_sensor_frame_decoder_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the tracker by one accepted byte; queue a reading on the sixth
    task automatic track_byte(input logic [7:0] b, input logic st);
        logic [2:0]  pos;
        reading_t    r;
        int          tc;
        int unsigned hc;
        pos = (st || frame_pos > POS_H_CRC) ? POS_T_MSB : frame_pos;
        if (st && frame_pos != POS_T_MSB)
            resyncs++;
        case (pos)
            POS_T_MSB:
            begin
                crc_acc = crc8_next(CRC_INIT, b);
                temp_word = {b, 8'h00};
                temp_bad = 1'b0;
            end
            POS_T_LSB:
            begin
                crc_acc = crc8_next(crc_acc, b);
                temp_word[7:0] = b;
            end
            POS_T_CRC:
            begin
                temp_bad = (crc_acc != b);
                crc_acc = CRC_INIT;
            end
            POS_H_MSB:
            begin
                crc_acc = crc8_next(CRC_INIT, b);
                hum_word = {b, 8'h00};
            end
            POS_H_LSB:
            begin
                crc_acc = crc8_next(crc_acc, b);
                hum_word[7:0] = b;
            end
            default:
            begin
                r = '0;
                if (temp_bad)
                    r.status = ST_TEMP_CRC;
                else if (crc_acc != b)
                    r.status = ST_HUM_CRC;
                else
                begin
                    tc = int'((32'(TEMP_SCALE) * 32'(temp_word)) / 32'(FULL_SCALE))
                         - int'(TEMP_OFFSET);
                    hc = (32'(HUM_SCALE) * 32'(hum_word)) / 32'(FULL_SCALE);
                    r.status = ST_OK;
                    r.temp = tc[14:0];
                    r.hum = hc[13:0];
                end
                expected_readings.push_back(r);
                crc_acc = CRC_INIT;
            end
        endcase
        frame_pos = (pos >= POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
    endtask

    // Ready is sampled at the falling edge, so it is the value seen at the next rise
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= st;
        @(negedge clk);
        while (s_tready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        track_byte(b, st);
        bytes_sent++;
    endtask

    // Send the first nbytes of a frame; a bad CRC gets a random nonzero flip
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input bit t_ok,
                              input bit h_ok, input logic st, input int nbytes);
        logic [7:0] fb[6];
        fb[0] = tw[15:8];
        fb[1] = tw[7:0];
        fb[2] = word_crc(tw) ^ (t_ok ? 8'h00 : 8'($urandom_range(1, 255)));
        fb[3] = hw[15:8];
        fb[4] = hw[7:0];
        fb[5] = word_crc(hw) ^ (h_ok ? 8'h00 : 8'($urandom_range(1, 255)));
        for (int i = 0; i < nbytes; i++)
            send_byte(fb[i], (i == 0) ? st : 1'b0);
    endtask

    // Stop offering and wait until every predicted reading has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // extremes with good CRCs
        send_frame(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
        // both CRCs bad, back to back without frame_start
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 6);
        // humidity CRC bad only
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b0, 6);
        // partial frame, then resync into a temperature CRC failure
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
        send_frame(16'hFF00, 16'h00FF, 1'b0, 1'b1, 1'b1, 6);
        wait_drain();
    endtask

    task automatic test_random_frames(input int target);
        int    stop_at;
        int    pick;
        logic  st;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            // mark the start whenever the tracker is mid-frame
            st = (frame_pos != POS_T_MSB) ? 1'b1 : 1'($urandom_range(0, 1));
            if (pick < 80)
                send_frame(rand_word(), rand_word(), $urandom_range(0, 7) != 0,
                           $urandom_range(0, 7) != 0, st, 6);
            else if (pick < 90)
                send_frame(rand_word(), rand_word(), $urandom_range(0, 1) != 0,
                           1'b1, st, $urandom_range(1, 5));
            else
                send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_req = 120;
        for (int i = 0; i < 8; i++)
            send_frame(rand_word(), rand_word(), 1'b1, 1'b1, 1'b1, 6);
        wait_drain();
    endtask

    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            send_frame(rand_word(), rand_word(), 1'b1, $urandom_range(0, 3) != 0, 1'b0, 6);
            wait_drain();
        end
    endtask

    task automatic test_back_to_back();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int i = 0; i < 20; i++)
            send_frame(rand_word(), rand_word(), $urandom_range(0, 5) != 0,
                       $urandom_range(0, 5) != 0, 1'b0, 6);
        wait_drain();
    endtask

    function automatic void note_mismatch(input string field, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on reading %0d: %s expected %0d, got %0d",
                     readings_checked, field, exp_v, act_v);
    endfunction

    // Reading sink: random stalls, a long hold on request, check each reading
    initial
    begin : reading_sink
        int       gap;
        reading_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req > 0)
            begin
                gap = hold_req;
                hold_req = 0;
            end
            else
                gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            // sample valid and data at the falling edge ahead of the accepting rise
            @(negedge clk);
            while (m_tvalid !== 1'b1)
                @(negedge clk);
            if (expected_readings.size() == 0)
            begin
                error_count++;
                $display("reading %h arrived with none predicted", m_tdata);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (m_tdata[14:0] !== want.temp)
                    note_mismatch("temperature", int'($signed(want.temp)),
                                  int'($signed(m_tdata[14:0])));
                if (m_tdata[28:15] !== want.hum)
                    note_mismatch("humidity", int'(want.hum), int'(m_tdata[28:15]));
                if (m_tdata[30:29] !== want.status)
                    note_mismatch("status", int'(want.status), int'(m_tdata[30:29]));
                if (want.status != ST_OK)
                    crc_fail_seen++;
            end
            readings_checked++;
            @(posedge clk);
        end
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames(1000);
        test_backpressure();
        test_drain_pause();
        test_back_to_back();
        repeat (10) @(posedge clk);
        error_count += expected_readings.size() + mismatch_count;
        $display("sent %0d bytes with %0d resyncs; checked %0d readings, %0d with CRC errors",
                 bytes_sent, resyncs, readings_checked, crc_fail_seen);
        $display("covered extremes, both CRC failures, resync, back-to-back and full stalls");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_queue.sv
design/hsfd_back.sv
design/humidity_sensor_frame_decoder_top.sv
dv/tb.sv
